/* hw/rtl/lcgr_pkg.sv */
// Shared types, constants and a helper function for the LCG range generator.
`timescale 1ns / 1ps
`default_nettype none

package lcgr_pkg;

    // Generator constants.
    localparam logic [31:0] LCG_MUL   = 32'd16807;
    localparam logic [31:0] LCG_ADD   = 32'h7fff_ffff;
    localparam logic [63:0] ROUND_UP  = 64'h0000_0000_7fff_ffff;
    localparam int          MAP_SHIFT = 31;

    // Stream widths.
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    // Request codes carried on s_tuser.
    typedef enum logic [1:0] {
        REQ_RESEED = 2'd0,
        REQ_INCL   = 2'd1,
        REQ_EXCL   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request and load the seed if needed
        logic step;     // advance the generator once
        logic mul;      // form the range product
        logic finish;   // form the result and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_t req;      // request held for the transaction in flight
        logic seeded;   // generator has been seeded since reset
    } status_t;

    // One generator step, modulo 2^32.
    function automatic logic [31:0] lcg_advance(input logic [31:0] s);
        logic [63:0] full;
        full = 64'(s) * 64'(LCG_MUL) + 64'(LCG_ADD);
        return full[31:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lcgr_datapath.sv */
// Datapath: generator state, range setup, range multiply and result register.
`timescale 1ns / 1ps
`default_nettype none

module lcgr_datapath (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lcgr_pkg::cmd_t          cmd,
    output lcgr_pkg::status_t            status,
    input  wire logic [1:0]              req_in,
    input  wire logic [95:0]             req_data,   // seed_value, range_low, range_high
    input  wire logic                    cfg_we,
    input  wire logic [31:0]             cfg_data,
    output logic [31:0]                  value_out,
    output logic [30:0]                  raw_out
);
    import lcgr_pkg::*;

    // Request fields.
    req_t        req_in_t;
    logic [31:0] seed_in;
    logic [31:0] low_in;
    logic [31:0] high_in;

    assign req_in_t = req_t'(req_in);
    assign seed_in  = req_data[31:0];
    assign low_in   = req_data[63:32];
    assign high_in  = req_data[95:64];

    // Architectural state.
    logic [31:0] state_reg, state_next;
    logic        seeded_reg, seeded_next;
    logic [31:0] reset_seed_reg, reset_seed_next;

    // Per-transaction registers.
    req_t        req_reg, req_next;
    logic [31:0] low_reg, low_next;
    logic [32:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [30:0] raw_reg, raw_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] value_reg, value_next;
    logic [30:0] raw_out_reg, raw_out_next;

    // Span setup: exact 34-bit difference of the bounds.
    logic signed [33:0] diff;
    logic signed [33:0] span_incl;
    logic signed [33:0] span_neg;

    assign diff      = $signed({{2{high_in[31]}}, high_in}) - $signed({{2{low_in[31]}}, low_in});
    assign span_incl = diff + 34'sd1;
    assign span_neg  = -span_incl;

    always_comb begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        if (cmd.load) begin
            case (req_in_t)
                REQ_INCL: begin
                    if (span_incl > 34'sd0) begin
                        mag_next = span_incl[32:0];
                        neg_next = 1'b0;
                    end else begin
                        mag_next = span_neg[32:0];
                        neg_next = 1'b1;
                    end
                end
                REQ_EXCL: begin
                    mag_next = (diff > 34'sd0) ? diff[32:0] : 33'd0;
                    neg_next = 1'b0;
                end
                default: begin
                    mag_next = 33'd0;
                    neg_next = 1'b0;
                end
            endcase
        end
    end

    // Generator state: load on a reseed or on the first draw, step on command.
    always_comb begin
        state_next      = state_reg;
        seeded_next     = seeded_reg;
        reset_seed_next = cfg_we ? cfg_data : reset_seed_reg;
        if (cmd.load) begin
            if (req_in_t == REQ_RESEED) begin
                state_next  = (seed_in == 32'd0) ? 32'd1 : seed_in;
                seeded_next = 1'b1;
            end else if ((req_in_t inside {REQ_INCL, REQ_EXCL}) && !seeded_reg) begin
                state_next  = reset_seed_reg;
                seeded_next = 1'b1;
            end
        end else if (cmd.step) begin
            state_next = lcg_advance(state_reg);
        end
    end

    // Request capture.
    assign req_next = cmd.load ? req_in_t : req_reg;
    assign low_next = cmd.load ? low_in : low_reg;

    // Range multiply: the only full-width span is 2^32, which is a shift.
    logic [30:0] raw_cur;
    logic [62:0] prod_mul;

    assign raw_cur  = state_reg[31:1];
    assign prod_mul = 63'(raw_cur) * 63'(mag_reg[31:0]);

    always_comb begin
        raw_next  = raw_reg;
        prod_next = prod_reg;
        if (cmd.mul) begin
            raw_next  = raw_cur;
            prod_next = mag_reg[32] ? {1'b0, raw_cur, 32'd0} : {1'b0, prod_mul};
        end
    end

    // Result: round for the reversed form, shift, and add to or subtract from the low bound.
    logic [63:0] rounded;
    logic [31:0] quot;

    assign rounded = prod_reg + (neg_reg ? ROUND_UP : 64'd0);
    assign quot    = rounded[MAP_SHIFT+31:MAP_SHIFT];

    always_comb begin
        value_next   = value_reg;
        raw_out_next = raw_out_reg;
        if (cmd.finish) begin
            if (req_reg inside {REQ_INCL, REQ_EXCL}) begin
                value_next   = neg_reg ? (low_reg - quot) : (low_reg + quot);
                raw_out_next = raw_reg;
            end else begin
                value_next   = 32'd0;
                raw_out_next = 31'd0;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= 32'd1;
            seeded_reg     <= 1'b0;
            reset_seed_reg <= 32'd1;
            req_reg        <= REQ_NONE;
        end else begin
            state_reg      <= state_next;
            seeded_reg     <= seeded_next;
            reset_seed_reg <= reset_seed_next;
            req_reg        <= req_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        low_reg     <= low_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        raw_reg     <= raw_next;
        prod_reg    <= prod_next;
        value_reg   <= value_next;
        raw_out_reg <= raw_out_next;
    end

    assign status.req    = req_reg;
    assign status.seeded = seeded_reg;
    assign value_out     = value_reg;
    assign raw_out       = raw_out_reg;

endmodule

`default_nettype wire

/* hw/rtl/lcgr_controller.sv */
// Controller: sequences each request and owns the stream handshakes.
`timescale 1ns / 1ps
`default_nettype none

module lcgr_controller (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [1:0]              req_in,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output lcgr_pkg::cmd_t               cmd,
    input  wire lcgr_pkg::status_t       status
);
    import lcgr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SEED_ADV = 5'b00010,
        ST_ADV      = 5'b00100,
        ST_MUL      = 5'b01000,
        ST_FIN      = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        out_free;
    req_t        req_in_t;

    assign req_in_t = req_t'(req_in);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    case (req_in_t)
                        REQ_RESEED: state_next = ST_ADV;
                        REQ_INCL, REQ_EXCL: begin
                            state_next = status.seeded ? ST_ADV : ST_SEED_ADV;
                        end
                        default: state_next = ST_FIN;
                    endcase
                end
            end
            ST_SEED_ADV: begin
                cmd.step   = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                cmd.step   = 1'b1;
                state_next = (status.req == REQ_RESEED) ? ST_FIN : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/lcg_random_range_generator_unit.sv */
// Top level of the LCG range generator: controller, datapath and stream ports.
// Each request runs through the controller states: an unused request code goes to FIN,
// a reseed through ADV and FIN, a draw through ADV, MUL and FIN, and the first draw after
// reset when not yet seeded through SEED_ADV first; FIN waits until the output is free.
// One request at a time: a new request can be taken in the cycle after the previous
// result is loaded. The steps are the generator step, the range multiply and the result add or subtract.
// Reset (aresetn low, synchronous) sets the state to 1, clears the seeded flag and
// sets the reset seed register to 1.
`timescale 1ns / 1ps
`default_nettype none

module lcg_random_range_generator_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lcgr_pkg::S_TDATA_W-1:0]    s_tdata,  // seed_value, range_low, range_high
    input  wire logic [lcgr_pkg::S_TUSER_W-1:0]    s_tuser,  // req_type
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lcgr_pkg::M_TDATA_W-1:0]         m_tdata,  // value, raw_draw, one zero bit
    // Configuration write channel (reset_seed).
    input  wire logic                              cfg_wvalid,
    output logic                                   cfg_wready,
    input  wire logic [31:0]                       cfg_wdata
);
    import lcgr_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [31:0] value;
    logic [30:0] raw_draw;

    assign cfg_wready = 1'b1;

    lcgr_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_in   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lcgr_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .req_in    (s_tuser),
        .req_data  (s_tdata),
        .cfg_we    (cfg_wvalid && cfg_wready),
        .cfg_data  (cfg_wdata),
        .value_out (value),
        .raw_out   (raw_draw)
    );

    assign m_tdata = {1'b0, raw_draw, value};

endmodule

`default_nettype wire

/* hw/rtl/lcgr_checker.sv */
// Port-level assertions for the LCG range generator and their bind.
`timescale 1ns / 1ps
`default_nettype none

module lcgr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // Reset leaves the block empty and ready for a request.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not idle after reset");

    // One request at a time: the input closes right after a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a transaction");

    // A new result only appears after the input was closed.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

    // A stalled result holds its data.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind lcg_random_range_generator_unit lcgr_checker u_lcgr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
